>>> sv/cota_pkg.sv
package cota_pkg;

	// field widths
	localparam int MS_W    = 22;
	localparam int DEPTH_W = 14;
	localparam int FO2_W   = 10;
	localparam int PO2O_W  = 15;
	localparam int ACC_W   = 48;

	// internal widths
	localparam int PO2_W     = 16;  // full quotient of the pO2 division
	localparam int MCAND_W   = 15;  // 330 + depth, or a band slope
	localparam int MPLIER_W  = 11;  // o2 fraction, or pO2 inside the table
	localparam int PROD_W    = MCAND_W + FO2_W;
	localparam int SLOPE_W   = 11;
	localparam int ICPT_W    = 21;  // intercept in milli-minutes
	localparam int LIMIT_W   = 20;
	localparam int DIVISOR_W = 26;  // 60 * limit

	localparam int MUL_STEPS = MPLIER_W;
	localparam int MCNT_W    = $clog2(MUL_STEPS);

	localparam int FRACTION_BITS_DEF = 32;

	localparam logic [MCAND_W-1:0]   SEA_TENTH_FT = MCAND_W'(330);
	localparam logic [PO2_W-1:0]     PO2_FLOOR    = PO2_W'(500);
	localparam logic [PO2_W-1:0]     PO2_CEIL     = PO2_W'(1600);
	localparam logic [PO2_W-1:0]     PO2_OUT_MAX  = PO2_W'(32767);
	localparam logic [ACC_W-1:0]     ACC_MAX      = {ACC_W{1'b1}};

	typedef struct packed {
		logic               op;
		logic [MS_W-1:0]    elapsed_ms;
		logic [DEPTH_W-1:0] depth_tenth_ft;
		logic [FO2_W-1:0]   o2_fraction_permille;
	} sample_t;

	typedef struct packed {
		logic [PO2O_W-1:0] po2_milli;
		logic [ACC_W-1:0]  cns_fraction;
		logic              above_table;
	} result_t;

	typedef enum logic {
		OP_ACCUM = 1'b0,
		OP_CLEAR = 1'b1
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_PO2,
		ST_PDIV_GO,
		ST_PDIV,
		ST_CHECK,
		ST_MUL_LIM,
		ST_LIMIT,
		ST_QDIV_GO,
		ST_QDIV,
		ST_FINISH
	} state_t;

	typedef enum logic [1:0] {
		RK_CLEAR,
		RK_HOLD,
		RK_SAT,
		RK_ADD
	} res_kind_t;

	typedef struct packed {
		logic [SLOPE_W-1:0] slope;
		logic [ICPT_W-1:0]  icpt;
	} band_t;

	// limit table, inclusive upper bounds in milli-atm
	function automatic band_t band_select(input logic [PO2_W-1:0] po2);
		band_t b;
		if (po2 <= PO2_W'(600)) begin
			b.slope = SLOPE_W'(1800); b.icpt = ICPT_W'(1800000);
		end else if (po2 <= PO2_W'(700)) begin
			b.slope = SLOPE_W'(1500); b.icpt = ICPT_W'(1620000);
		end else if (po2 <= PO2_W'(800)) begin
			b.slope = SLOPE_W'(1200); b.icpt = ICPT_W'(1410000);
		end else if (po2 <= PO2_W'(900)) begin
			b.slope = SLOPE_W'(900);  b.icpt = ICPT_W'(1170000);
		end else if (po2 <= PO2_W'(1100)) begin
			b.slope = SLOPE_W'(600);  b.icpt = ICPT_W'(900000);
		end else if (po2 <= PO2_W'(1500)) begin
			b.slope = SLOPE_W'(300);  b.icpt = ICPT_W'(570000);
		end else begin
			b.slope = SLOPE_W'(750);  b.icpt = ICPT_W'(1245000);
		end
		return b;
	endfunction

endpackage

>>> sv/cns_oxygen_toxicity_accumulator_top.sv
// cns oxygen toxicity accumulator. each input word either clears the
// accumulator or adds one time step of exposure: pO2 = fO2*(330+depth)/330 in
// milli-atm, a limit from the seven-band table when pO2 is in 501..1600, and
// elapsed_ms*2^FRACTION_BITS/(60*limit) added to a saturating 48-bit sum in
// which 2^FRACTION_BITS is 100 percent. pO2 above 1600 saturates the sum and
// raises above_table. every input word gives exactly one result word. the
// block works on one word at a time: multiplies are shift-and-add over the
// multiplier bits and both divisions share one restoring divider that yields
// one quotient bit per cycle. a step inside the table spends most of its time
// in the divider. a finished result sits in an output register, so the next
// word can be taken while it waits; a second finished result holds the block
// until the first one is taken.
module cns_oxygen_toxicity_accumulator_top #(
	parameter int FRACTION_BITS = cota_pkg::FRACTION_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_stall,
	input  cota_pkg::sample_t sample,
	output logic              result_valid,
	input  logic              result_stall,
	output cota_pkg::result_t result
);

	import cota_pkg::*;

	localparam int DW    = MS_W + FRACTION_BITS;
	localparam int CW    = $clog2(DW + 1);
	localparam int SUM_W = ((DW > ACC_W) ? DW : ACC_W) + 1;

	state_t state_q, state_d;

	// control outputs of the sequencer
	logic sample_take;
	logic div_start;
	logic out_load;
	logic mul_step;

	// datapath registers
	res_kind_t            res_kind_q;
	logic [MS_W-1:0]      ms_q;
	logic [MCAND_W-1:0]   mcand_q;
	logic [MPLIER_W-1:0]  mplier_q;
	logic [PROD_W-1:0]    mul_acc_q;
	logic [MCNT_W-1:0]    mul_cnt_q;
	logic [PO2_W-1:0]     po2_q;
	logic [ICPT_W-1:0]    icpt_q;
	logic [LIMIT_W-1:0]   limit_q;
	logic [DW-1:0]        inc_q;
	logic [ACC_W-1:0]     acc_q;
	logic                 result_valid_q;
	result_t              result_q;

	// divider hookup
	logic [DW-1:0]        div_dividend;
	logic [DIVISOR_W-1:0] div_divisor;
	logic [CW-1:0]        div_steps;
	logic                 div_busy;
	logic [DW-1:0]        div_quot;

	logic [PROD_W-1:0]    mul_next;
	logic [ICPT_W-1:0]    limit_full;
	logic [SUM_W-1:0]     acc_sum;
	logic [ACC_W-1:0]     acc_next;
	logic [PO2O_W-1:0]    po2_out;
	band_t                band;
	logic                 out_free;

	assign out_free = !result_valid_q || !result_stall;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		sample_take  = 1'b0;
		div_start    = 1'b0;
		out_load     = 1'b0;
		mul_step     = 1'b0;
		sample_stall = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (sample_valid) begin
					sample_take = 1'b1;
					state_d = (sample.op == OP_CLEAR) ? ST_FINISH : ST_MUL_PO2;
				end
			end
			ST_MUL_PO2: begin
				mul_step = 1'b1;
				if (mul_cnt_q == '0) begin
					state_d = ST_PDIV_GO;
				end
			end
			ST_PDIV_GO: begin
				div_start = 1'b1;
				state_d   = ST_PDIV;
			end
			ST_PDIV: begin
				if (!div_busy) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (po2_q > PO2_CEIL || po2_q <= PO2_FLOOR) begin
					state_d = ST_FINISH;
				end else begin
					state_d = ST_MUL_LIM;
				end
			end
			ST_MUL_LIM: begin
				mul_step = 1'b1;
				if (mul_cnt_q == '0) begin
					state_d = ST_LIMIT;
				end
			end
			ST_LIMIT: begin
				state_d = ST_QDIV_GO;
			end
			ST_QDIV_GO: begin
				div_start = 1'b1;
				state_d   = ST_QDIV;
			end
			ST_QDIV: begin
				if (!div_busy) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// shift-and-add multiplier, multiplier msb first
	assign mul_next = {mul_acc_q[PROD_W-2:0], 1'b0}
		+ (mplier_q[MPLIER_W-1] ? {{(PROD_W-MCAND_W){1'b0}}, mcand_q} : '0);

	assign band       = band_select(po2_q);
	assign limit_full = icpt_q - mul_acc_q[ICPT_W-1:0];

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (sample_take) begin
					res_kind_q <= RK_CLEAR;
					ms_q       <= sample.elapsed_ms;
					mcand_q    <= SEA_TENTH_FT + {1'b0, sample.depth_tenth_ft};
					mplier_q   <= {{(MPLIER_W-FO2_W){1'b0}}, sample.o2_fraction_permille};
					mul_acc_q  <= '0;
					mul_cnt_q  <= MCNT_W'(MUL_STEPS - 1);
				end
			end
			ST_MUL_PO2, ST_MUL_LIM: begin
				mul_acc_q <= mul_next;
				mplier_q  <= {mplier_q[MPLIER_W-2:0], 1'b0};
				mul_cnt_q <= mul_cnt_q - MCNT_W'(1);
			end
			ST_PDIV: begin
				po2_q <= div_quot[PO2_W-1:0];
			end
			ST_CHECK: begin
				if (po2_q > PO2_CEIL) begin
					res_kind_q <= RK_SAT;
				end else begin
					res_kind_q <= RK_HOLD;
				end
				// pO2 inside the table fits the short multiplier
				mcand_q   <= {{(MCAND_W-SLOPE_W){1'b0}}, band.slope};
				icpt_q    <= band.icpt;
				mplier_q  <= po2_q[MPLIER_W-1:0];
				mul_acc_q <= '0;
				mul_cnt_q <= MCNT_W'(MUL_STEPS - 1);
			end
			ST_LIMIT: begin
				limit_q <= limit_full[LIMIT_W-1:0];
			end
			ST_QDIV: begin
				inc_q      <= div_quot;
				res_kind_q <= RK_ADD;
			end
			default: begin
			end
		endcase
	end

	// both divisions share one unit; the pO2 dividend is aligned to the top
	always_comb begin
		if (state_q == ST_QDIV_GO) begin
			div_dividend = {ms_q, {FRACTION_BITS{1'b0}}};
			div_divisor  = {limit_q, 6'b0} - {4'b0, limit_q, 2'b0};
			div_steps    = CW'(DW);
		end else begin
			div_dividend = {mul_acc_q, {(DW-PROD_W){1'b0}}};
			div_divisor  = {{(DIVISOR_W-MCAND_W){1'b0}}, SEA_TENTH_FT};
			div_steps    = CW'(PROD_W);
		end
	end

	cota_serdiv #(
		.DW (DW),
		.VW (DIVISOR_W),
		.CW (CW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.steps    (div_steps),
		.busy     (div_busy),
		.quotient (div_quot)
	);

	// saturating update of the accumulator
	assign acc_sum = SUM_W'(acc_q) + SUM_W'(inc_q);

	always_comb begin
		case (res_kind_q)
			RK_CLEAR: acc_next = '0;
			RK_HOLD:  acc_next = acc_q;
			RK_SAT:   acc_next = ACC_MAX;
			RK_ADD:   acc_next = (acc_sum > SUM_W'(ACC_MAX)) ? ACC_MAX : acc_sum[ACC_W-1:0];
			default:  acc_next = acc_q;
		endcase
	end

	assign po2_out = (po2_q > PO2_OUT_MAX) ? PO2_OUT_MAX[PO2O_W-1:0] : po2_q[PO2O_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				acc_q          <= acc_next;
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			result_q.po2_milli    <= (res_kind_q == RK_CLEAR) ? '0 : po2_out;
			result_q.cns_fraction <= acc_next;
			result_q.above_table  <= (res_kind_q == RK_SAT);
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// flag over the table always comes with a full accumulator
	a_above_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.above_table) |-> (result.cns_fraction == ACC_MAX))
		else $error("above_table without saturated accumulator");

	// only a clear can lower the accumulator
	a_acc_mono: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && res_kind_q != RK_CLEAR) |=> (acc_q >= $past(acc_q)))
		else $error("accumulator decreased without a clear");

	// the shared divider is never restarted mid-run
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider started while busy");

	// result register is only loaded when it is free
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> ($stable(result) && result_valid))
		else $error("waiting result word overwritten");

endmodule

>>> sv/cota_serdiv.sv
module cota_serdiv #(
	parameter int DW = 54,
	parameter int VW = 26,
	parameter int CW = $clog2(DW + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	input  logic [CW-1:0] steps,
	output logic          busy,
	output logic [DW-1:0] quotient
);

	logic [DW-1:0] dvd_q;
	logic [VW-1:0] rem_q;
	logic [VW-1:0] dsr_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;

	logic [VW:0] shifted;
	logic [VW:0] diff;
	logic        fits;

	// restoring division, one quotient bit per cycle
	always_comb begin
		shifted = {rem_q, dvd_q[DW-1]};
		fits    = (shifted >= {1'b0, dsr_q});
		diff    = shifted - {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= steps;
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DW-2:0], fits};
			rem_q <= fits ? diff[VW-1:0] : shifted[VW-1:0];
		end
	end

	assign busy     = busy_q;
	assign quotient = dvd_q;

endmodule

>>> verif/cns_oxygen_toxicity_accumulator_top_tb.sv
// self-checking bench for the cns oxygen toxicity accumulator
module cns_oxygen_toxicity_accumulator_top_tb;

	import cota_pkg::*;

	localparam int FRAC = FRACTION_BITS_DEF;
	localparam int CYCLE_LIMIT = 1000000;
	// drain past the longest in-table step
	localparam int DRAIN_CYCLES = 250;
	// long receiver hold-off, well past two full steps so the input backs up
	localparam int HOLD_CYCLES = 400;
	localparam int HOLD_AFTER = 30;

	logic    clk;
	logic    arst_n = 1'b0;
	logic    sample_valid = 1'b0;
	logic    sample_stall;
	sample_t sample = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	// idle percentages of the current phase, read by the driver and the sink
	int send_pct = 0;
	int recv_pct = 0;

	// expected result words and the running toxicity sum behind them
	class exposure_board;
		logic [ACC_W-1:0] cns_sum;
		result_t due_q[$];
		int errors;

		function new();
			cns_sum = '0;
			errors = 0;
		endfunction

		task report(string msg);
			errors++;
			$display("mismatch: %s", msg);
		endtask

		// exposure limit in milli-minutes for a pO2 inside 501..1600
		function longint unsigned limit_mmin(longint unsigned p);
			if (p <= 600) return 64'd1800000 - 64'd1800 * p;
			if (p <= 700) return 64'd1620000 - 64'd1500 * p;
			if (p <= 800) return 64'd1410000 - 64'd1200 * p;
			if (p <= 900) return 64'd1170000 - 64'd900 * p;
			if (p <= 1100) return 64'd900000 - 64'd600 * p;
			if (p <= 1500) return 64'd570000 - 64'd300 * p;
			return 64'd1245000 - 64'd750 * p;
		endfunction

		// one step of the exposure sum, returns the word the block should give
		function result_t exposure_step(sample_t s);
			result_t r;
			longint unsigned po2;
			longint unsigned dose;
			longint unsigned room;
			r = '0;
			if (op_t'(s.op) == OP_CLEAR) begin
				cns_sum = '0;
				return r;
			end
			po2 = (64'(s.o2_fraction_permille) * (64'(SEA_TENTH_FT) + 64'(s.depth_tenth_ft)))
				/ 64'(SEA_TENTH_FT);
			if (po2 > 64'(PO2_CEIL)) begin
				cns_sum = ACC_MAX;
				r.above_table = 1'b1;
			end else if (po2 > 64'(PO2_FLOOR)) begin
				dose = (64'(s.elapsed_ms) << FRAC) / (64'd60 * limit_mmin(po2));
				room = 64'(ACC_MAX) - 64'(cns_sum);
				if (dose > room)
					cns_sum = ACC_MAX;
				else
					cns_sum = cns_sum + ACC_W'(dose);
			end
			r.po2_milli = (po2 > 64'(PO2_OUT_MAX)) ? PO2O_W'(PO2_OUT_MAX) : PO2O_W'(po2);
			r.cns_fraction = cns_sum;
			return r;
		endfunction

		function void note_sample(sample_t s);
			due_q.push_back(exposure_step(s));
		endfunction

		task check_result(result_t got);
			result_t want;
			if (due_q.size() == 0) begin
				report($sformatf("unexpected word po2=%0d cns=%0d above=%0d",
					got.po2_milli, got.cns_fraction, got.above_table));
				return;
			end
			want = due_q.pop_front();
			if (got.po2_milli !== want.po2_milli)
				report($sformatf("po2_milli got %0d expected %0d",
					got.po2_milli, want.po2_milli));
			if (got.cns_fraction !== want.cns_fraction)
				report($sformatf("cns_fraction got %0d expected %0d",
					got.cns_fraction, want.cns_fraction));
			if (got.above_table !== want.above_table)
				report($sformatf("above_table got %0d expected %0d",
					got.above_table, want.above_table));
		endtask

		function int pending();
			return due_q.size();
		endfunction
	endclass

	exposure_board board = new();

	cns_oxygen_toxicity_accumulator_top #(
		.FRACTION_BITS(FRAC)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog: ends a hung run
	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("TB_ERROR");
		$finish;
	end

	// result sink: checks every accepted word, then picks next cycle's stall
	initial begin
		int results_seen;
		int hold_left;
		bit hold_done;
		results_seen = 0;
		hold_left = 0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (result_valid === 1'b1 && result_stall === 1'b0) begin
				board.check_result(result);
				results_seen++;
			end
			// one long hold-off early on, while the driver keeps offering words
			if (!hold_done && results_seen == HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= (recv_pct != 0) && ($urandom_range(99) < recv_pct);
			end
		end
	end

	function automatic sample_t make_sample(op_t op, int unsigned ms, int unsigned depth,
		int unsigned fo2);
		sample_t s;
		s.op = op;
		s.elapsed_ms = MS_W'(ms);
		s.depth_tenth_ft = DEPTH_W'(depth);
		s.o2_fraction_permille = FO2_W'(fo2);
		return s;
	endfunction

	// mostly realistic dive steps inside the table, with clears, raw noise and
	// the odd step past the table mixed in
	function automatic sample_t random_sample();
		int unsigned pick;
		int unsigned ms;
		pick = $urandom_range(99);
		if (pick < 10)
			return make_sample(OP_CLEAR, $urandom, $urandom, $urandom);
		if (pick < 15)
			return make_sample(OP_ACCUM, $urandom, $urandom, $urandom);
		if (pick < 17)
			return make_sample(OP_ACCUM, $urandom_range(3600000),
				$urandom_range(10000, 2000), $urandom_range(1000, 800));
		if ($urandom_range(9) == 0)
			ms = $urandom_range(3600000);
		else
			ms = $urandom_range(60000);
		return make_sample(OP_ACCUM, ms, $urandom_range(300), $urandom_range(800, 150));
	endfunction

	// offers one word, with an optional idle gap first, and waits for the handshake
	task automatic send_word(sample_t w);
		if (send_pct != 0 && $urandom_range(99) < send_pct) begin
			sample_valid <= 1'b0;
			repeat ($urandom_range(120, 1)) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample <= w;
		@(posedge clk);
		while (sample_stall !== 1'b0) @(posedge clk);
		board.note_sample(w);
	endtask

	task automatic run_phase(int idle_pct, int stall_pct, int words);
		send_pct = idle_pct;
		recv_pct = stall_pct;
		repeat (words) send_word(random_sample());
	endtask

	initial begin
		int unsigned edge_po2[10];
		int unsigned all_ms;
		int unsigned all_depth;
		int unsigned all_fo2;
		edge_po2 = '{500, 501, 600, 601, 700, 701, 800, 801, 900, 901};
		all_ms = (1 << MS_W) - 1;
		all_depth = (1 << DEPTH_W) - 1;
		all_fo2 = (1 << FO2_W) - 1;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: clear ignores its other fields
		send_word(make_sample(OP_CLEAR, all_ms, all_depth, all_fo2));
		// zero pO2
		send_word(make_sample(OP_ACCUM, 0, 0, 0));
		// band edges at the surface, pO2 equals the oxygen fraction
		foreach (edge_po2[i])
			send_word(make_sample(OP_ACCUM, 60000, 0, edge_po2[i]));
		// upper bands reached with depth at 100 percent oxygen
		send_word(make_sample(OP_ACCUM, 60000, 0, 1000));
		send_word(make_sample(OP_ACCUM, 60000, 33, 1000));
		send_word(make_sample(OP_ACCUM, 60000, 34, 1000));
		send_word(make_sample(OP_ACCUM, 60000, 165, 1000));
		send_word(make_sample(OP_ACCUM, 60000, 166, 1000));
		send_word(make_sample(OP_ACCUM, 3600000, 198, 1000));
		send_word(make_sample(OP_ACCUM, all_ms, 198, 1000));
		// zero-length step inside the table
		send_word(make_sample(OP_ACCUM, 0, 0, 700));
		// just past the table with no elapsed time still saturates
		send_word(make_sample(OP_ACCUM, 0, 199, 1000));
		// adding to a full sum saturates
		send_word(make_sample(OP_ACCUM, 1000, 0, 700));
		// every field at its widest, pO2 output clipped
		send_word(make_sample(OP_ACCUM, all_ms, all_depth, all_fo2));
		send_word(make_sample(OP_CLEAR, 0, 0, 0));

		// random phases: free running, sender gaps, receiver stalls, both
		run_phase(0, 0, 257);
		run_phase(60, 0, 257);
		run_phase(0, 60, 257);
		run_phase(22, 22, 257);
		sample_valid <= 1'b0;

		while (board.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

>>> filelist.f
sv/cota_pkg.sv
sv/cota_serdiv.sv
sv/cns_oxygen_toxicity_accumulator_top.sv
verif/cns_oxygen_toxicity_accumulator_top_tb.sv
